// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file dnr_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/dnr_pkg.sv =====
package dnr_pkg;

    // byte codes
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_EXP_U = 8'h45;
    localparam logic [7:0] CHAR_EXP_L = 8'h65;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        CLS_NUL   = 3'd0,
        CLS_SIGN  = 3'd1,
        CLS_DIGIT = 3'd2,
        CLS_POINT = 3'd3,
        CLS_EXP   = 3'd4,
        CLS_OTHER = 3'd5
    } char_class_t;

    typedef struct packed {
        char_class_t cls;
        logic        last;
    } dnr_entry_t;

endpackage

// ===== rtl/core/dnr_front.sv =====
module dnr_front
    import dnr_pkg::*;
(
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_in,
    input  logic       last,
    output logic       push_valid,
    input  logic       push_ready,
    output dnr_entry_t push_data
);

    function automatic char_class_t classify(input logic [7:0] c);
        char_class_t r;
        r = CLS_OTHER;
        if (c == CHAR_NUL) r = CLS_NUL;
        else if (c == CHAR_PLUS || c == CHAR_MINUS) r = CLS_SIGN;
        else if (c >= CHAR_ZERO && c <= CHAR_NINE) r = CLS_DIGIT;
        else if (c == CHAR_POINT) r = CLS_POINT;
        else if (c == CHAR_EXP_U || c == CHAR_EXP_L) r = CLS_EXP;
        return r;
    endfunction

    assign push_valid     = in_valid;
    assign in_ready       = push_ready;
    assign push_data.cls  = classify(char_in);
    assign push_data.last = last;

endmodule

// ===== rtl/core/dnr_queue.sv =====
module dnr_queue
    import dnr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  dnr_entry_t push_data,
    output logic       pop_valid,
    input  logic       pop_ready,
    output dnr_entry_t pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    dnr_entry_t       slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push, pop;

    assign push_ready = (cnt_reg != CNT_FULL);
    assign pop_valid  = (cnt_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/dnr_back.sv =====
module dnr_back
    import dnr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pop_valid,
    output logic       pop_ready,
    input  dnr_entry_t pop_data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       is_valid
);

    typedef enum logic [8:0] {
        ST_START    = 9'b000000001,
        ST_SIGN     = 9'b000000010,
        ST_INT      = 9'b000000100,
        ST_DOT_ONLY = 9'b000001000,
        ST_FRAC     = 9'b000010000,
        ST_EXP      = 9'b000100000,
        ST_EXP_SIGN = 9'b001000000,
        ST_EXP_DIG  = 9'b010000000,
        ST_REJECT   = 9'b100000000
    } parse_state_t;

    parse_state_t state_reg, state_next, stepped;
    logic         term_reg, term_next;
    logic         out_valid_reg, out_valid_next;
    logic         is_valid_reg, is_valid_next;
    logic         pop;

    function automatic parse_state_t step(input parse_state_t st, input char_class_t cls);
        parse_state_t r;
        r = ST_REJECT;
        unique case (st)
            ST_START:
            begin
                if (cls == CLS_SIGN) r = ST_SIGN;
                else if (cls == CLS_DIGIT) r = ST_INT;
                else if (cls == CLS_POINT) r = ST_DOT_ONLY;
            end
            ST_SIGN:
            begin
                if (cls == CLS_DIGIT) r = ST_INT;
                else if (cls == CLS_POINT) r = ST_DOT_ONLY;
            end
            ST_INT:
            begin
                if (cls == CLS_DIGIT) r = ST_INT;
                else if (cls == CLS_POINT) r = ST_FRAC;
                else if (cls == CLS_EXP) r = ST_EXP;
            end
            ST_DOT_ONLY:
            begin
                if (cls == CLS_DIGIT) r = ST_FRAC;
            end
            ST_FRAC:
            begin
                if (cls == CLS_DIGIT) r = ST_FRAC;
                else if (cls == CLS_EXP) r = ST_EXP;
            end
            ST_EXP:
            begin
                if (cls == CLS_SIGN) r = ST_EXP_SIGN;
                else if (cls == CLS_DIGIT) r = ST_EXP_DIG;
            end
            ST_EXP_SIGN, ST_EXP_DIG:
            begin
                if (cls == CLS_DIGIT) r = ST_EXP_DIG;
            end
            default: r = ST_REJECT;
        endcase
        return r;
    endfunction

    // a non-final byte never needs the output register
    assign pop_ready = !pop_data.last || !out_valid_reg || out_ready;
    assign pop       = pop_valid && pop_ready;
    assign out_valid = out_valid_reg;
    assign is_valid  = is_valid_reg;

    always_comb
    begin
        stepped = state_reg;
        if (!term_reg && pop_data.cls != CLS_NUL)
        begin
            stepped = step(state_reg, pop_data.cls);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        term_next      = term_reg;
        out_valid_next = out_valid_reg && !out_ready;
        is_valid_next  = is_valid_reg;
        if (pop)
        begin
            if (pop_data.last)
            begin
                state_next     = ST_START;
                term_next      = 1'b0;
                out_valid_next = 1'b1;
                is_valid_next  = (stepped == ST_INT) || (stepped == ST_FRAC)
                                 || (stepped == ST_EXP_DIG);
            end
            else
            begin
                state_next = stepped;
                term_next  = term_reg || (pop_data.cls == CLS_NUL);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_START;
            term_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            term_reg      <= term_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_valid_reg <= is_valid_next;
    end

endmodule

// ===== rtl/core/decimal_number_recognizer.sv =====
// decimal number recognizer: a string comes in one byte per transaction, its final byte
// flagged by last, and one verdict transaction (is_valid) leaves per string, valid for an
// optional sign, digits with at most one point (at least one digit before any exponent) and
// an optional exponent e/E, optional sign, one or more digits; a zero byte ends the string
// early and the bytes after it up to last are ignored. one byte is taken every cycle while
// the queue has room; the single-state-register parse loop in the back end sets that rate.
// the last byte passes through the queue and then sets the verdict register. a stalled
// verdict does not stop the next string's bytes until its final byte reaches the back end;
// that byte then waits at the head of the DEPTH-entry queue, and input stops once it is full.
module decimal_number_recognizer
    import dnr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_in,
    input  logic       last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       is_valid
);

    // front to queue
    logic       push_valid;
    logic       push_ready;
    dnr_entry_t push_data;

    // queue to back
    logic       pop_valid;
    logic       pop_ready;
    dnr_entry_t pop_data;

    // front: classifies each byte into a small character class
    dnr_front u_front
    (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .char_in    (char_in),
        .last       (last),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // queue decouples a stalled verdict from the byte stream
    dnr_queue #(
        .DEPTH (DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // back: parse state machine and the verdict register
    dnr_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .is_valid  (is_valid)
    );

endmodule

// ===== rtl/core/dnr_checker.sv =====
`include "assert_macros.svh"

module dnr_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] char_in,
    input logic       last,
    input logic       out_valid,
    input logic       out_ready,
    input logic       is_valid
);

    logic [8:0] in_payload;

    assign in_payload = {char_in, last};

    // a waiting byte keeps its payload
    `ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid && $stable(in_payload))

    // a stalled verdict holds its value
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(is_valid))

    // a verdict only leaves after being taken
    `ASSERT_SAME(a_out_drop, clk, rst_n, $fell(out_valid), $past(out_ready))

    // with the output free the queue drains, so a full queue opens the next cycle
    `ASSERT_NEXT(a_drain, clk, rst_n, !out_valid && !in_ready, in_ready)

    // input back-pressure that persists needs a stalled verdict
    `ASSERT_SAME(a_stall_cause, clk, rst_n, !in_ready && !$past(in_ready), $past(out_valid))

endmodule

bind decimal_number_recognizer dnr_checker u_dnr_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_in   (char_in),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .is_valid  (is_valid)
);

// ===== tb/decimal_number_checker.sv =====
module decimal_number_checker
    import dnr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] char_in,
    input  logic       last,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic       is_valid,
    output int         fail_count,
    output int         pending
);

    typedef enum logic [3:0] {
        PS_START    = 4'd0,
        PS_SIGN     = 4'd1,
        PS_INT      = 4'd2,
        PS_DOT_ONLY = 4'd3,
        PS_FRAC     = 4'd4,
        PS_EXP      = 4'd5,
        PS_EXP_SIGN = 4'd6,
        PS_EXP_DIG  = 4'd7,
        PS_REJECT   = 4'd8
    } scan_state_t;

    scan_state_t scan_state;
    logic        scan_done;
    logic        verdict_q[$];
    logic        want;

    function automatic scan_state_t scan_next(scan_state_t st, logic [7:0] c);
        logic dg;
        logic sg;
        logic pt;
        logic ex;
        dg = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        sg = (c == CHAR_PLUS) || (c == CHAR_MINUS);
        pt = (c == CHAR_POINT);
        ex = (c == CHAR_EXP_U) || (c == CHAR_EXP_L);
        case (st)
            PS_START:
                return sg ? PS_SIGN : dg ? PS_INT : pt ? PS_DOT_ONLY : PS_REJECT;
            PS_SIGN:
                return dg ? PS_INT : pt ? PS_DOT_ONLY : PS_REJECT;
            PS_INT:
                return dg ? PS_INT : pt ? PS_FRAC : ex ? PS_EXP : PS_REJECT;
            PS_DOT_ONLY:
                return dg ? PS_FRAC : PS_REJECT;
            PS_FRAC:
                return dg ? PS_FRAC : ex ? PS_EXP : PS_REJECT;
            PS_EXP:
                return sg ? PS_EXP_SIGN : dg ? PS_EXP_DIG : PS_REJECT;
            PS_EXP_SIGN, PS_EXP_DIG:
                return dg ? PS_EXP_DIG : PS_REJECT;
            default:
                return PS_REJECT;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_state = PS_START;
            scan_done  = 1'b0;
            verdict_q.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            // verdict side
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $display("%0t: unexpected verdict, expected none, actual %0b",
                             $time, is_valid);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (is_valid !== want)
                    begin
                        $display("%0t: is_valid mismatch, expected %0b, actual %0b",
                                 $time, want, is_valid);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // byte side
            if (in_valid && in_ready)
            begin
                if (!scan_done)
                begin
                    if (char_in == CHAR_NUL)
                        scan_done = 1'b1;
                    else
                        scan_state = scan_next(scan_state, char_in);
                end
                if (last)
                begin
                    verdict_q.push_back((scan_state == PS_INT) || (scan_state == PS_FRAC) ||
                                        (scan_state == PS_EXP_DIG));
                    scan_state = PS_START;
                    scan_done  = 1'b0;
                end
            end
            pending <= verdict_q.size();
        end
    end

endmodule

// ===== tb/tb_decimal_number_recognizer.sv =====
module tb_decimal_number_recognizer;
    import dnr_pkg::*;

    // bytes to send outside the directed strings, counted up to the end byte
    localparam int RANDOM_BYTES = 1850;
    // run stops here no matter what; far above the slowest correct run
    localparam int CYCLE_LIMIT  = 200000;
    // extra cycles after the last verdict
    localparam int DRAIN_CYCLES = 16;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] char_in   = 8'h00;
    logic       last      = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       is_valid;

    int         fail_count;
    int         pending;
    int         cycle_cnt = 0;
    int         random_sent;

    // current string, one entry per byte
    logic [7:0] str_q[$];

    // calm stretches: no idling on that side while set
    logic       in_calm  = 1'b0;
    logic       out_calm = 1'b0;

    always #6 clk = ~clk;

    decimal_number_recognizer u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .char_in  (char_in),
        .last     (last),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .is_valid (is_valid)
    );

    decimal_number_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_in   (char_in),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .is_valid  (is_valid),
        .fail_count(fail_count),
        .pending   (pending)
    );

    // load a plain text string into the byte queue
    task automatic load_text(input string s);
        int i;
        str_q.delete();
        for (i = 0; i < s.len(); i++)
            str_q.push_back(s[i]);
    endtask

    // send the byte queue as one string, last on the final byte; returns
    // how many bytes the block actually parses (up to and including a nul)
    task automatic send_string(output int parsed);
        int  i;
        int  gap;
        bit  seen_nul;
        parsed   = 0;
        seen_nul = 1'b0;
        for (i = 0; i < str_q.size(); i++)
        begin
            if ($urandom_range(0, 39) == 0)
                in_calm = ~in_calm;
            gap = in_calm ? 0 : $urandom_range(0, 4);
            if (gap > 0)
            begin
                // valid drops only between transactions, never while one is pending
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            char_in  <= str_q[i];
            last     <= (i == str_q.size() - 1);
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            if (!seen_nul)
                parsed++;
            if (str_q[i] == CHAR_NUL)
                seen_nul = 1'b1;
        end
    endtask

    function automatic logic [7:0] rand_digit();
        logic [7:0] d;
        d = 8'($urandom_range(0, 9));
        return CHAR_ZERO + d;
    endfunction

    // mostly well-formed numbers with random content, the rest broken or noise
    task automatic build_random_string();
        int         kind;
        int         n;
        int         i;
        int         pos;
        int         nint;
        int         nfrac;
        bit         has_point;
        logic [7:0] b;
        str_q.delete();
        kind = $urandom_range(0, 99);
        if (kind < 5)
        begin
            // empty string
            str_q.push_back(CHAR_NUL);
        end
        else if (kind < 15)
        begin
            // random bytes of any value
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++)
            begin
                b = 8'($urandom_range(0, 255));
                str_q.push_back(b);
            end
        end
        else
        begin
            if ($urandom_range(0, 2) == 0)
                str_q.push_back($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
            nint      = $urandom_range(0, 4);
            nfrac     = $urandom_range(0, 4);
            has_point = 1'($urandom_range(0, 1));
            if (!has_point && nint == 0)
                nint = 1;
            if (has_point && nint == 0 && nfrac == 0)
                nfrac = 1;
            for (i = 0; i < nint; i++)
                str_q.push_back(rand_digit());
            if (has_point)
            begin
                str_q.push_back(CHAR_POINT);
                for (i = 0; i < nfrac; i++)
                    str_q.push_back(rand_digit());
            end
            if ($urandom_range(0, 2) == 0)
            begin
                str_q.push_back($urandom_range(0, 1) ? CHAR_EXP_U : CHAR_EXP_L);
                if ($urandom_range(0, 1))
                    str_q.push_back($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++)
                    str_q.push_back(rand_digit());
            end
            // break about a third of the well-formed strings
            if (kind >= 75)
            begin
                pos = $urandom_range(0, str_q.size() - 1);
                case ($urandom_range(0, 3))
                    0:
                    begin
                        // overwrite one byte with anything
                        b = 8'($urandom_range(0, 255));
                        str_q[pos] = b;
                    end
                    1:
                    begin
                        // stray point, sign or exponent mark
                        case ($urandom_range(0, 2))
                            0: b = CHAR_POINT;
                            1: b = $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS;
                            default: b = $urandom_range(0, 1) ? CHAR_EXP_U : CHAR_EXP_L;
                        endcase
                        str_q.insert(pos, b);
                    end
                    2:
                    begin
                        // early end byte followed by bytes that must be ignored
                        str_q.insert(pos, CHAR_NUL);
                        n = $urandom_range(0, 3);
                        for (i = 0; i < n; i++)
                        begin
                            b = 8'($urandom_range(0, 255));
                            str_q.push_back(b);
                        end
                    end
                    default:
                    begin
                        // drop the tail byte, e.g. leaving a bare exponent
                        if (str_q.size() > 1)
                            void'(str_q.pop_back());
                    end
                endcase
            end
        end
    endtask

    // hard stop on a hung handshake
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("decimal_number_recognizer test failed");
            $finish;
        end
    end

    // verdict side: random stalls between transactions, with calm stretches
    initial
    begin : verdict_sink
        int gap;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 29) == 0)
                out_calm = ~out_calm;
            gap = out_calm ? 0 : $urandom_range(0, 4);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    initial
    begin : byte_source
        int parsed;
        // reset is held at the start, then released once for the whole run
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed strings: empty, extremes, every char class, edge states
        load_text("");
        str_q.push_back(CHAR_NUL);
        send_string(parsed);
        load_text("0");
        send_string(parsed);
        load_text("-.5");
        send_string(parsed);
        load_text("+.");
        send_string(parsed);
        load_text("9e+1");
        send_string(parsed);
        load_text("1E");
        send_string(parsed);
        load_text("1.2.");
        send_string(parsed);
        // early end byte, then an ignored byte with every bit set
        load_text("1");
        str_q.push_back(CHAR_NUL);
        str_q.push_back(8'hFF);
        send_string(parsed);
        load_text("");
        str_q.push_back(8'hFF);
        send_string(parsed);
        load_text(".e1");
        send_string(parsed);
        load_text(" 7");
        send_string(parsed);

        // random strings until enough parsed bytes have gone in
        random_sent = 0;
        while (random_sent < RANDOM_BYTES)
        begin
            build_random_string();
            send_string(parsed);
            random_sent += parsed;
        end
        in_valid <= 1'b0;

        // let the checker count settle, then drain the outstanding verdicts
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("decimal_number_recognizer test passed");
        else
            $display("decimal_number_recognizer test failed");
        $finish;
    end

endmodule

// ===== decimal_number_recognizer.f =====
+incdir+rtl/core
rtl/core/dnr_pkg.sv
rtl/core/dnr_front.sv
rtl/core/dnr_queue.sv
rtl/core/dnr_back.sv
rtl/core/decimal_number_recognizer.sv
rtl/core/dnr_checker.sv
tb/decimal_number_checker.sv
tb/tb_decimal_number_recognizer.sv
